// File: sv/tli_pkg.sv
// shared types and constants for the table linear interpolator
package tli_pkg;

	localparam int VAL_W     = 32;
	localparam int IDX_W     = 8;
	localparam int CNT_W     = 9;
	localparam int REG_W     = 2;
	localparam int FRAC_W    = 16;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;
	localparam int PROD_W    = 50;

	localparam logic [CNT_W-1:0] CNT_RESET = 9'd2;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// result region codes
	localparam logic [REG_W-1:0] REGION_INTERIOR = 2'd0;
	localparam logic [REG_W-1:0] REGION_LOW      = 2'd1;
	localparam logic [REG_W-1:0] REGION_HIGH     = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_FIRST,
		S_CHK_FIRST,
		S_CHK_LAST,
		S_SCAN,
		S_SEG,
		S_DIV,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

	// table read address source
	typedef enum logic [2:0] {
		ADDR_FIRST,
		ADDR_LAST,
		ADDR_ONE,
		ADDR_NEXT,
		ADDR_PREV
	} addr_sel_t;

	typedef struct packed {
		logic      wr_point;
		logic      load_z;
		addr_sel_t addr_sel;
		logic      j_init;
		logic      j_step;
		logic      save_hi;
		logic      seg_setup;
		logic      div_step;
		logic      mul;
		logic      res_interior;
		logic      res_low;
		logic      res_high;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic z_lt_rd;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// File: sv/tli_ifs.sv
// word channels of the table linear interpolator

interface tli_item_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [7:0]         point_index;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] position;

	modport source (output valid, op, point_index, point_x, point_y, position, input ready);
	modport sink (input valid, op, point_index, point_x, point_y, position, output ready);
endinterface

interface tli_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         region;

	modport source (output valid, value, region, input ready);
	modport sink (input valid, value, region, output ready);
endinterface

// File: sv/tli_ctrl.sv
// controller state machine for the table linear interpolator
module tli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	input  tli_pkg::status_t  status,
	output tli_pkg::cmd_t     cmd
);
	import tli_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_op == OP_EVAL) state_d = S_RD_FIRST;
			end
			S_RD_FIRST:  state_d = S_CHK_FIRST;
			S_CHK_FIRST: state_d = status.z_lt_rd ? S_DONE : S_CHK_LAST;
			S_CHK_LAST:  state_d = status.z_lt_rd ? S_SCAN : S_DONE;
			S_SCAN: begin
				if (status.z_lt_rd) state_d = S_SEG;
			end
			S_SEG: state_d = S_DIV;
			S_DIV: begin
				if (status.div_last) state_d = S_MUL;
			end
			S_MUL: state_d = S_ADD;
			S_ADD: state_d = S_DONE;
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr_point = (in_op == OP_WRITE);
					cmd.load_z   = (in_op == OP_EVAL);
				end
			end
			S_RD_FIRST: cmd.addr_sel = ADDR_FIRST;
			S_CHK_FIRST: begin
				if (status.z_lt_rd) begin
					cmd.res_low = 1'b1;
				end else begin
					cmd.addr_sel = ADDR_LAST;
				end
			end
			S_CHK_LAST: begin
				if (status.z_lt_rd) begin
					cmd.addr_sel = ADDR_ONE;
					cmd.j_init   = 1'b1;
				end else begin
					cmd.res_high = 1'b1;
				end
			end
			S_SCAN: begin
				if (status.z_lt_rd) begin
					cmd.save_hi  = 1'b1;
					cmd.addr_sel = ADDR_PREV;
				end else begin
					cmd.addr_sel = ADDR_NEXT;
					cmd.j_step   = 1'b1;
				end
			end
			S_SEG: cmd.seg_setup = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_MUL: cmd.mul = 1'b1;
			S_ADD: cmd.res_interior = 1'b1;
			S_DONE: cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: sv/tli_datapath.sv
// table memories, segment search, divider, multiplier and result register
module tli_datapath #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tli_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic [tli_pkg::IDX_W-1:0]         point_index,
	input  logic signed [tli_pkg::VAL_W-1:0]  point_x,
	input  logic signed [tli_pkg::VAL_W-1:0]  point_y,
	input  logic signed [tli_pkg::VAL_W-1:0]  position,
	input  tli_pkg::cmd_t                     cmd,
	output tli_pkg::status_t                  status,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic signed [tli_pkg::VAL_W-1:0]  out_value,
	output logic [tli_pkg::REG_W-1:0]         out_region
);
	import tli_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [VAL_W-1:0]        x_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]        y_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]        cnt_q;
	logic signed [VAL_W-1:0] z_q;
	logic signed [VAL_W-1:0] rdx_q, rdy_q;
	logic [AW-1:0]           j_q;
	logic signed [VAL_W-1:0] x1_q, y1_q, y0_q;
	logic [VAL_W-1:0]        rem_q, dx_q;
	logic [FRAC_W-1:0]       quo_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;
	logic signed [VAL_W:0]   dy_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [VAL_W-1:0] res_val_q;
	logic [REG_W-1:0]        res_reg_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [REG_W-1:0]        out_region_q;

	logic [AW-1:0]           wr_addr, rd_addr, last_idx;
	logic                    wr_ok;
	logic [31:0]             last_w;
	logic signed [VAL_W:0]   diff_w, dx_w, dy_w;
	logic [VAL_W:0]          rem_sh;

	// point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_RESET;
		end else if (cfg_we) begin
			cnt_q <= cfg_wdata;
		end
	end

	// index of the last point in use, count clamped to 1..TABLE_DEPTH
	always_comb begin
		if (cnt_q == '0) begin
			last_w = '0;
		end else if (32'(cnt_q) > TABLE_DEPTH) begin
			last_w = 32'(TABLE_DEPTH - 1);
		end else begin
			last_w = 32'(cnt_q) - 32'd1;
		end
		last_idx = last_w[AW-1:0];
	end

	// table write port
	assign wr_ok   = 32'(point_index) < TABLE_DEPTH;
	assign wr_addr = AW'(point_index);

	always_ff @(posedge clk) begin
		if (cmd.wr_point && wr_ok) begin
			x_mem[wr_addr] <= point_x;
			y_mem[wr_addr] <= point_y;
		end
	end

	// table read address
	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_FIRST: rd_addr = '0;
			ADDR_LAST:  rd_addr = last_idx;
			ADDR_ONE:   rd_addr = AW'(1);
			ADDR_NEXT:  rd_addr = j_q + AW'(1);
			ADDR_PREV:  rd_addr = j_q - AW'(1);
			default:    rd_addr = '0;
		endcase
	end

	// registered table read
	always_ff @(posedge clk) begin
		rdx_q <= x_mem[rd_addr];
		rdy_q <= y_mem[rd_addr];
	end

	// segment differences
	assign diff_w = {z_q[VAL_W-1], z_q} - {rdx_q[VAL_W-1], rdx_q};
	assign dx_w   = {x1_q[VAL_W-1], x1_q} - {rdx_q[VAL_W-1], rdx_q};
	assign dy_w   = {y1_q[VAL_W-1], y1_q} - {rdy_q[VAL_W-1], rdy_q};
	assign rem_sh = {rem_q, 1'b0};

	// search and arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load_z) z_q <= position;
		if (cmd.j_init) j_q <= AW'(1);
		else if (cmd.j_step) j_q <= j_q + AW'(1);
		if (cmd.save_hi) begin
			x1_q <= rdx_q;
			y1_q <= rdy_q;
		end
		// one restoring division step per cycle
		if (cmd.seg_setup) begin
			rem_q     <= diff_w[VAL_W-1:0];
			dx_q      <= dx_w[VAL_W-1:0];
			dy_q      <= dy_w;
			y0_q      <= rdy_q;
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, dx_q}) begin
				rem_q <= VAL_W'(rem_sh - {1'b0, dx_q});
				quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[VAL_W-1:0];
				quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		if (cmd.mul) prod_q <= $signed({1'b0, quo_q}) * dy_q;
		// result staging
		if (cmd.res_interior) begin
			res_val_q <= y0_q + prod_q[FRAC_W+VAL_W-1:FRAC_W];
			res_reg_q <= REGION_INTERIOR;
		end else if (cmd.res_low) begin
			res_val_q <= rdy_q;
			res_reg_q <= REGION_LOW;
		end else if (cmd.res_high) begin
			res_val_q <= rdy_q;
			res_reg_q <= REGION_HIGH;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q  <= res_val_q;
			out_region_q <= res_reg_q;
		end
	end

	// status to the controller
	assign status.z_lt_rd  = z_q < rdx_q;
	assign status.div_last = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_region = out_region_q;

endmodule

// File: sv/table_linear_interpolator.sv
// Piecewise linear lookup table, signed Q16.16, with point writes and evaluations.
// The items channel takes two kinds of word: a write word (op 0) stores point_x
// and point_y at point_index; an evaluate word (op 1) gives one
// word on the results channel with the value and its region.
// The point count register is written through cfg_we/cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
// An evaluation reads the first point and, below it, gives the low clamp; else it
// reads the last point and, at or above it, gives the high clamp; else it scans
// the x table from entry 1, one entry per cycle through the registered memory
// read, then runs a bit-serial restoring divider for the 16-bit fraction, a multiply and an add.
// One evaluation is in flight at a time; the next word is taken the cycle after
// the result has moved to the output register. A finished word may wait in the
// output register while the block takes the next item.
// If the receiver stalls, the result holds in the output register and the
// block stops before loading the next result.
// Reset clears the controller, the output valid and sets the count to 2;
// the table contents stay undefined until written.
module table_linear_interpolator #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tli_pkg::CNT_W-1:0] cfg_wdata,
	tli_item_if.sink                  items,
	tli_result_if.source              results
);
	import tli_pkg::*;

	cmd_t    cmd;
	status_t status;

	// controller
	tli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_op    (items.op),
		.in_ready (items.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	tli_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.point_index (items.point_index),
		.point_x     (items.point_x),
		.point_y     (items.point_y),
		.position    (items.position),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_value   (results.value),
		.out_region  (results.region)
	);

endmodule

// File: tb/tb.sv
// testbench for the table linear interpolator: directed and random point writes and evaluations checked
module tb;
	import tli_pkg::*;

	localparam int DEPTH = 256;
	localparam int ITEMS = 1100;
	localparam int DRAIN_CYCLES = 300;
	localparam int LIMIT = 3000000;
	localparam longint XMIN = -64'sd2147483648;
	localparam longint XMAX = 64'sd2147483647;
	localparam longint SPAN = 64'sd4294967295;

	typedef struct {
		logic               op;
		logic [7:0]         idx;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pos;
	} table_word_t;

	typedef struct {
		logic signed [31:0] value;
		logic [1:0]         region;
	} interp_out_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	tli_item_if   item_ch();
	tli_result_if result_ch();

	table_linear_interpolator #(.TABLE_DEPTH(DEPTH)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (item_ch),
		.results   (result_ch)
	);

	// predictor state: point table and count setting
	logic signed [31:0] pt_x [DEPTH];
	logic signed [31:0] pt_y [DEPTH];
	logic [CNT_W-1:0]   count_setting;

	// what the stimulus side believes the table holds
	logic signed [31:0] plan_x [DEPTH];
	logic signed [31:0] plan_y [DEPTH];

	table_word_t word_queue [$];
	interp_out_t due_results [$];
	table_word_t on_wire;
	bit          word_on_wire;
	int          send_gap;
	int          send_calm;
	int          hold_left;
	int          recv_calm;
	int          taken;
	int          bad_results;
	int          queued_total;
	int unsigned cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// count zero acts as one, above the depth acts as the depth
	function automatic int used_count(logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return int'(c);
	endfunction

	// clamp or interpolate at position z over the current table
	function automatic interp_out_t interp_predict(logic signed [31:0] z);
		interp_out_t o;
		int          n;
		int          j;
		int          seg;
		bit          found;
		longint      x0, x1, y0, y1, diff, dx, w, prod, res;
		n = used_count(count_setting);
		if (z < pt_x[0]) begin
			o.value = pt_y[0];
			o.region = REGION_LOW;
			return o;
		end
		if (z >= pt_x[n-1]) begin
			o.value = pt_y[n-1];
			o.region = REGION_HIGH;
			return o;
		end
		// segment before the first later x that lies above z
		seg = 0;
		found = 0;
		for (j = 1; j < n; j++) begin
			if (!found && z < pt_x[j]) begin
				seg = j - 1;
				found = 1;
			end
		end
		x0 = pt_x[seg];
		x1 = pt_x[seg+1];
		y0 = pt_y[seg];
		y1 = pt_y[seg+1];
		diff = longint'(z) - x0;
		dx = x1 - x0;
		w = (diff <<< 16) / dx;
		prod = w * (y1 - y0);
		res = y0 + (prod >>> 16);
		o.value = res[31:0];
		o.region = REGION_INTERIOR;
		return o;
	endfunction

	// an accepted word updates the table or yields one expected result
	function automatic void apply_word(table_word_t w);
		if (w.op == OP_WRITE) begin
			pt_x[w.idx] = w.px;
			pt_y[w.idx] = w.py;
		end else begin
			due_results = {due_results, interp_predict(w.pos)};
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic longint rand_upto(longint span);
		return $urandom_range(32'(span), 0);
	endfunction

	// random word with a bias toward the extremes
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 15))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return 32'h00000000;
			3: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic void queue_write(logic [7:0] idx, logic [31:0] x, logic [31:0] y);
		table_word_t w;
		w.op = OP_WRITE;
		w.idx = idx;
		w.px = x;
		w.py = y;
		w.pos = $urandom;
		plan_x[idx] = x;
		plan_y[idx] = y;
		word_queue = {word_queue, w};
		queued_total++;
	endfunction

	// unused fields carry junk
	function automatic void queue_eval(logic [31:0] z);
		table_word_t w;
		w.op = OP_EVAL;
		w.idx = 8'($urandom);
		w.px = $urandom;
		w.py = $urandom;
		w.pos = z;
		word_queue = {word_queue, w};
		queued_total++;
	endfunction

	// strictly increasing x over entries 0..n-1, random spread and steps
	function automatic void fill_table(int n);
		longint step_max;
		longint xv;
		longint st;
		int     i;
		step_max = SPAN / n;
		if ($urandom_range(0, 2) == 0)
			step_max = step_max >> $urandom_range(1, 24);
		if (step_max < 1)
			step_max = 1;
		xv = XMIN + rand_upto(SPAN - (n - 1) * step_max);
		for (i = 0; i < n; i++) begin
			if (i > 0) begin
				case ($urandom_range(0, 9))
					0: st = 1;
					1, 2, 3: st = 1 + rand_upto(((step_max < 65536) ? step_max : 65536) - 1);
					default: st = 1 + rand_upto(step_max - 1);
				endcase
				xv += st;
			end
			queue_write(i[7:0], xv[31:0], pick_word());
		end
	endfunction

	// mostly evaluations aimed at the table, some rewrites and noise
	function automatic void queue_random_word();
		int                 n, r, i;
		longint             lo, hi, z;
		logic [7:0]         idx;
		logic signed [31:0] raw;
		n = used_count(count_setting);
		if ($urandom_range(0, 99) < 30) begin
			idx = 8'($urandom);
			if ($urandom_range(0, 4) == 0)
				queue_write(idx, pick_word(), pick_word());
			else
				queue_write(idx, plan_x[idx], pick_word());
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 55 && n >= 2) begin
			i = $urandom_range(0, n - 2);
			lo = plan_x[i];
			hi = plan_x[i+1];
			if (hi <= lo)
				z = lo;
			else begin
				case ($urandom_range(0, 9))
					0: z = lo;
					1: z = hi - 1;
					default: z = lo + rand_upto(hi - lo - 1);
				endcase
			end
		end else if (r < 68) begin
			z = plan_x[$urandom_range(0, n - 1)];
		end else if (r < 80) begin
			lo = plan_x[0];
			z = (lo > XMIN) ? lo - 1 - rand_upto(lo - 1 - XMIN) : lo;
		end else if (r < 90) begin
			hi = plan_x[n-1];
			z = hi + rand_upto(XMAX - hi);
		end else begin
			raw = $urandom;
			z = raw;
		end
		queue_eval(z[31:0]);
	endfunction

	// wait until every word is taken and every result has come
	task automatic settle();
		do
			@(posedge clk);
		while (word_queue.size() != 0 || word_on_wire || due_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		count_setting = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				apply_word(on_wire);
				word_on_wire = 0;
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(0, 49) == 0)
						send_calm = $urandom_range(30, 120);
				end
			end
			if (word_on_wire) begin
				// hold the offered word
			end else if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				on_wire = word_queue.pop_front();
				word_on_wire = 1;
				item_ch.op <= on_wire.op;
				item_ch.point_index <= on_wire.idx;
				item_ch.point_x <= on_wire.px;
				item_ch.point_y <= on_wire.py;
				item_ch.position <= on_wire.pos;
				item_ch.valid <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin : take_results
		interp_out_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				taken++;
				if (due_results.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("unexpected result word: value %h region %0d",
							result_ch.value, result_ch.region);
				end else begin
					want = due_results.pop_front();
					if (result_ch.value !== want.value || result_ch.region !== want.region) begin
						bad_results++;
						if (bad_results <= 10)
							$display("result %0d: value %h expected %h, region %0d expected %0d",
								taken, result_ch.value, want.value, result_ch.region,
								want.region);
					end
				end
				// long hold so the block fills up and stalls its input
				if (taken == 30 || taken == 300)
					hold_left = 600;
				else if (recv_calm > 0) begin
					recv_calm--;
					hold_left = 0;
				end else begin
					hold_left = pick_gap();
					if ($urandom_range(0, 39) == 0)
						recv_calm = $urandom_range(20, 80);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus: directed words, then phases of count settings and random words
	initial begin
		int i;
		int n;
		int words;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_WRITE;
		item_ch.point_index = '0;
		item_ch.point_x = '0;
		item_ch.point_y = '0;
		item_ch.position = '0;
		result_ch.ready = 1'b0;
		word_on_wire = 0;
		send_calm = 0;
		recv_calm = 0;
		taken = 0;
		bad_results = 0;
		queued_total = 0;
		cycles = 0;
		count_setting = CNT_RESET;
		for (i = 0; i < DEPTH; i++) begin
			plan_x[i] = '0;
			plan_y[i] = '0;
			pt_x[i] = '0;
			pt_y[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// full-range segment, falling from the top to the bottom
		queue_write(8'd0, 32'h80000000, 32'h7FFFFFFF);
		queue_write(8'd1, 32'h7FFFFFFF, 32'h80000000);
		queue_eval(32'h80000000);
		queue_eval(32'h00000000);
		queue_eval(32'h7FFFFFFE);
		queue_eval(32'h7FFFFFFF);
		// 1.0 to 2.0 mapped to 0.0 to 3.0: clamps, ends and midpoint
		queue_write(8'd0, 32'h00010000, 32'h00000000);
		queue_write(8'd1, 32'h00020000, 32'h00030000);
		queue_eval(32'h80000000);
		queue_eval(32'h0000FFFF);
		queue_eval(32'h00010000);
		queue_eval(32'h00018000);
		queue_eval(32'h0001FFFF);
		queue_eval(32'h00020000);
		// unit-width segment
		queue_write(8'd0, 32'h00000005, 32'hFFFFFFFF);
		queue_write(8'd1, 32'h00000006, 32'h80000000);
		queue_eval(32'h00000005);
		queue_eval(32'h00000006);
		queue_eval(32'h00000004);
		// top index, and a shallow falling slope that needs flooring
		queue_write(8'd255, 32'hFFFFFFFF, 32'h00000001);
		queue_write(8'd1, 32'h00030000, 32'hFFFFFFFE);
		queue_eval(32'h00018001);
		queue_eval(32'h0002ABCD);

		// single point
		settle();
		set_count(9'd1);
		for (i = 0; i < 15; i++)
			queue_random_word();

		// count zero behaves as one point
		settle();
		set_count(9'd0);
		for (i = 0; i < 15; i++)
			queue_random_word();

		// full table
		settle();
		set_count(9'd256);
		fill_table(DEPTH);
		for (i = 0; i < 60; i++)
			queue_random_word();

		// count above the depth
		settle();
		set_count(9'd511);
		for (i = 0; i < 40; i++)
			queue_random_word();

		// every entry is written from here on, so any count is safe
		while (queued_total < ITEMS) begin
			settle();
			if ($urandom_range(0, 99) < 85) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 12);
				set_count(n[CNT_W-1:0]);
				fill_table(n);
			end else begin
				set_count(CNT_W'($urandom_range(0, 511)));
			end
			words = $urandom_range(30, 80);
			for (i = 0; i < words; i++)
				queue_random_word();
		end

		settle();
		if (bad_results == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
